FILE: src/sdiff_pkg.sv
// Shared constants, types and helpers for the second-difference error block.
// No dependencies.
`default_nettype none

package sdiff_pkg;

  localparam int MAX_SIZE_X_DEF  = 64;
  localparam int MAX_SIZE_Y_DEF  = 64;
  localparam int MAX_SIZE_Z_DEF  = 64;
  localparam int VALUE_WIDTH_DEF = 32;
  localparam int AXIS_COUNT_DEF  = 3;

  localparam int FIELD_COUNT     = 5;
  localparam int CFG_WIDTH       = 7;
  localparam int CFG_INDEX_WIDTH = 2;
  localparam int INDEX_WIDTH     = 6;
  localparam int MIN_SIZE        = 3;

  // RAM copies, one per stencil tap read each cycle
  localparam int TAP_COUNT = 6;
  localparam int TAP_C     = 0;
  localparam int TAP_XM    = 1;
  localparam int TAP_XP    = 2;
  localparam int TAP_YM    = 3;
  localparam int TAP_YP    = 4;
  localparam int TAP_ZO    = 5;

  localparam logic [CFG_WIDTH-1:0] SIZE_RESET = CFG_WIDTH'(64);

  typedef enum logic [CFG_INDEX_WIDTH-1:0] {
    REG_SIZE_X = 2'd0,
    REG_SIZE_Y = 2'd1,
    REG_SIZE_Z = 2'd2
  } sdiff_reg_t;

  typedef struct packed {
    logic [INDEX_WIDTH-1:0] index_x;
    logic [INDEX_WIDTH-1:0] index_y;
    logic [INDEX_WIDTH-1:0] index_z;
    logic                   last_point;
  } sdiff_meta_t;

  // size register clamped to [MIN_SIZE, maxv]
  function automatic logic [CFG_WIDTH-1:0] eff_size(input logic [CFG_WIDTH-1:0] v,
                                                    input int maxv);
    int vi;
    int r;
    vi = int'(v);
    r  = vi;
    if (vi < MIN_SIZE) r = MIN_SIZE;
    else if (vi > maxv) r = maxv;
    return CFG_WIDTH'(r);
  endfunction

endpackage

`default_nettype wire

FILE: src/sdiff_point_if.sv
// Input channel: one grid point per word, five signed fields.
// Depends on nothing.
`default_nettype none

interface sdiff_point_if #(
  parameter int VALUE_WIDTH = 32
);
  logic                          valid;
  logic                          ready;
  logic signed [VALUE_WIDTH-1:0] density;
  logic signed [VALUE_WIDTH-1:0] momentum_x;
  logic signed [VALUE_WIDTH-1:0] momentum_y;
  logic signed [VALUE_WIDTH-1:0] momentum_z;
  logic signed [VALUE_WIDTH-1:0] total_energy;

  modport source (output valid, density, momentum_x, momentum_y, momentum_z, total_energy,
                  input ready);
  modport sink   (input valid, density, momentum_x, momentum_y, momentum_z, total_energy,
                  output ready);
endinterface

`default_nettype wire

FILE: src/sdiff_error_if.sv
// Output channel: error value and center indices, one word per interior point.
// Depends on nothing.
`default_nettype none

interface sdiff_error_if #(
  parameter int VALUE_WIDTH = 32
);
  logic                   valid;
  logic                   ready;
  logic [VALUE_WIDTH:0]   error_value;
  logic [5:0]             index_x;
  logic [5:0]             index_y;
  logic [5:0]             index_z;
  logic                   last_point;

  modport source (output valid, error_value, index_x, index_y, index_z, last_point,
                  input ready);
  modport sink   (input valid, error_value, index_x, index_y, index_z, last_point,
                  output ready);
endinterface

`default_nettype wire

FILE: src/sdiff_ram.sv
// Generic single-write, single-read RAM with registered, read-first output.
// Depends on nothing.
`default_nettype none

module sdiff_ram #(
  parameter int WIDTH = 160,
  parameter int DEPTH = 8192
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic                     re,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);
  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (re) rdata <= mem[raddr];
    if (we) mem[waddr] <= wdata;
  end
endmodule

`default_nettype wire

FILE: src/sdiff_lane.sv
// One field lane: absolute second differences per axis, then their maximum.
// Two register stages; uses sdiff_pkg.
`default_nettype none

module sdiff_lane #(
  parameter int VALUE_WIDTH = 32,
  parameter int AXIS_COUNT  = 3
) (
  input  wire logic                          clk,
  input  wire logic                          en_a,
  input  wire logic                          en_b,
  input  wire logic signed [VALUE_WIDTH-1:0] center,
  input  wire logic signed [VALUE_WIDTH-1:0] x_minus,
  input  wire logic signed [VALUE_WIDTH-1:0] x_plus,
  input  wire logic signed [VALUE_WIDTH-1:0] y_minus,
  input  wire logic signed [VALUE_WIDTH-1:0] y_plus,
  input  wire logic signed [VALUE_WIDTH-1:0] z_minus,
  input  wire logic signed [VALUE_WIDTH-1:0] z_plus,
  output logic             [VALUE_WIDTH:0]   lane_max
);
  import sdiff_pkg::*;

  localparam int DW = VALUE_WIDTH + 3;

  logic signed [VALUE_WIDTH-1:0] lo [3];
  logic signed [VALUE_WIDTH-1:0] hi [3];
  logic [VALUE_WIDTH:0] mag_next [AXIS_COUNT];
  logic [VALUE_WIDTH:0] mag      [AXIS_COUNT];
  logic [VALUE_WIDTH:0] lane_max_next;

  assign lo[0] = x_minus;
  assign hi[0] = x_plus;
  assign lo[1] = y_minus;
  assign hi[1] = y_plus;
  assign lo[2] = z_minus;
  assign hi[2] = z_plus;

  always_comb begin
    logic signed [DW-1:0] d;
    for (int a = 0; a < AXIS_COUNT; a++) begin
      d = DW'(lo[a]) - (DW'(center) <<< 1) + DW'(hi[a]);
      mag_next[a] = d[DW-1] ? (VALUE_WIDTH+1)'(-d) : (VALUE_WIDTH+1)'(d);
    end
  end

  always_ff @(posedge clk) begin
    if (en_a) mag <= mag_next;
  end

  always_comb begin
    lane_max_next = '0;
    for (int a = 0; a < AXIS_COUNT; a++) begin
      if (mag[a] > lane_max_next) lane_max_next = mag[a];
    end
  end

  always_ff @(posedge clk) begin
    if (en_b) lane_max <= lane_max_next;
  end
endmodule

`default_nettype wire

FILE: src/sdiff_merge.sv
// Merging stage: maximum over the field lanes into the output register.
// Uses sdiff_pkg.
`default_nettype none

module sdiff_merge #(
  parameter int VALUE_WIDTH = 32
) (
  input  wire logic                   clk,
  input  wire logic                   en,
  input  wire logic [VALUE_WIDTH:0]   lane_max [sdiff_pkg::FIELD_COUNT],
  output logic      [VALUE_WIDTH:0]   error_max
);
  import sdiff_pkg::*;

  logic [VALUE_WIDTH:0] error_max_next;

  always_comb begin
    error_max_next = lane_max[0];
    for (int f = 1; f < FIELD_COUNT; f++) begin
      if (lane_max[f] > error_max_next) error_max_next = lane_max[f];
    end
  end

  always_ff @(posedge clk) begin
    if (en) error_max <= error_max_next;
  end
endmodule

`default_nettype wire

FILE: src/stencil_second_difference_error_unit.sv
// Second-difference regridding error over a 3D grid streamed in raster order.
// Channels: points (sink) takes one grid point per word, x fastest, then y, z.
//   errors (source) gives one word for each interior point of plane k-1 once
//   the point at the same (x, y) of plane k has arrived; boundary points give
//   no word but are stored.
// Config: cfg_we/cfg_index/cfg_data write size_x, size_y, size_z (reset 64);
//   write only while no word is in flight.
// Throughput: one point per cycle unless errors.ready back-pressure stalls it, set by
//   the six RAM copies that each supply one stencil tap per cycle.
// Pipeline: an accepted point passes the RAM read, difference, lane max and
//   merge registers in that order before its result word is valid.
// Reset clears the position counters and pipeline valids and sets the sizes
//   to 64; history RAM contents are not cleared and need none.
// When errors.ready is low, words collect in the pipeline registers; the
//   input keeps flowing until a stage that must hold meets a full stage.
// Depends on sdiff_pkg, sdiff_point_if, sdiff_error_if, sdiff_ram,
// sdiff_lane, sdiff_merge.
`default_nettype none

module stencil_second_difference_error_unit #(
  parameter int MAX_SIZE_X  = sdiff_pkg::MAX_SIZE_X_DEF,
  parameter int MAX_SIZE_Y  = sdiff_pkg::MAX_SIZE_Y_DEF,
  parameter int MAX_SIZE_Z  = sdiff_pkg::MAX_SIZE_Z_DEF,
  parameter int VALUE_WIDTH = sdiff_pkg::VALUE_WIDTH_DEF,
  parameter int AXIS_COUNT  = sdiff_pkg::AXIS_COUNT_DEF
) (
  input  wire logic                                   clk,
  input  wire logic                                   rst,
  input  wire logic                                   cfg_we,
  input  wire logic [sdiff_pkg::CFG_INDEX_WIDTH-1:0]  cfg_index,
  input  wire logic [sdiff_pkg::CFG_WIDTH-1:0]        cfg_data,
  sdiff_point_if.sink                                 points,
  sdiff_error_if.source                               errors
);
  import sdiff_pkg::*;

  localparam int XW  = $clog2(MAX_SIZE_X);
  localparam int YW  = $clog2(MAX_SIZE_Y);
  localparam int ZW  = $clog2(MAX_SIZE_Z);
  localparam int AW  = 1 + YW + XW;
  localparam int RW  = FIELD_COUNT * VALUE_WIDTH;
  localparam int MXW = (XW > YW) ? XW : YW;
  localparam int MW  = (MXW > ZW) ? MXW : ZW;
  localparam int CW  = ((MW > CFG_WIDTH) ? MW : CFG_WIDTH) + 2;

  // configuration
  logic [CFG_WIDTH-1:0] size_x, size_y, size_z;

  always_ff @(posedge clk) begin
    if (rst) begin
      size_x <= SIZE_RESET;
      size_y <= SIZE_RESET;
      size_z <= SIZE_RESET;
    end else if (cfg_we) begin
      unique case (sdiff_reg_t'(cfg_index))
        REG_SIZE_X: size_x <= cfg_data;
        REG_SIZE_Y: size_y <= cfg_data;
        REG_SIZE_Z: size_z <= cfg_data;
        default: ;
      endcase
    end
  end

  logic [CW-1:0] sx, sy, sz;
  assign sx = CW'(eff_size(size_x, MAX_SIZE_X));
  assign sy = CW'(eff_size(size_y, MAX_SIZE_Y));
  assign sz = CW'(eff_size(size_z, MAX_SIZE_Z));

  // pipeline control
  logic v1, v2, v3, v4;
  logic en1, en2, en3, en4;
  logic accept;

  assign en4 = !v4 || errors.ready;
  assign en3 = !v3 || en4;
  assign en2 = !v2 || en3;
  assign en1 = !v1 || en2;
  assign points.ready = en1;
  assign accept = points.valid && en1;

  // position counters
  logic [XW-1:0] col;
  logic [YW-1:0] row;
  logic [ZW-1:0] pln;
  logic [CW-1:0] ci, rj, pk;
  logic [CW-1:0] ci_inc, rj_inc, pk_inc;

  assign ci = CW'(col);
  assign rj = CW'(row);
  assign pk = CW'(pln);
  assign ci_inc = ci + CW'(1);
  assign rj_inc = rj + CW'(1);
  assign pk_inc = pk + CW'(1);

  always_ff @(posedge clk) begin
    if (rst) begin
      col <= '0;
      row <= '0;
      pln <= '0;
    end else if (accept) begin
      if (ci_inc >= sx) begin
        col <= '0;
        if (rj_inc >= sy) begin
          row <= '0;
          pln <= (pk_inc >= sz) ? '0 : ZW'(pk_inc);
        end else begin
          row <= YW'(rj_inc);
        end
      end else begin
        col <= XW'(ci_inc);
      end
    end
  end

  logic interior;
  sdiff_meta_t meta0;

  assign interior = (pk >= CW'(2)) && (pk_inc <= sz) &&
                    (ci >= CW'(1)) && (ci + CW'(2) <= sx) &&
                    (rj >= CW'(1)) && (rj + CW'(2) <= sy);

  always_comb begin
    logic [CW-1:0] pk_dec;
    pk_dec = pk - CW'(1);
    meta0.index_x    = ci[INDEX_WIDTH-1:0];
    meta0.index_y    = rj[INDEX_WIDTH-1:0];
    meta0.index_z    = pk_dec[INDEX_WIDTH-1:0];
    meta0.last_point = (ci + CW'(2) == sx) && (rj + CW'(2) == sy) && (pk_inc == sz);
  end

  // history: plane parity, row, column; six copies, one per tap
  logic [RW-1:0] cur_row;
  logic [AW-1:0] waddr;
  logic [AW-1:0] raddr [TAP_COUNT];
  logic [RW-1:0] rdata [TAP_COUNT];
  logic          op, cp;

  assign cur_row = {points.total_energy, points.momentum_z, points.momentum_y,
                    points.momentum_x, points.density};
  assign op = pln[0];
  assign cp = ~pln[0];
  assign waddr = {op, row, col};
  assign raddr[TAP_C]  = {cp, row, col};
  assign raddr[TAP_XM] = {cp, row, col - XW'(1)};
  assign raddr[TAP_XP] = {cp, row, col + XW'(1)};
  assign raddr[TAP_YM] = {cp, row - YW'(1), col};
  assign raddr[TAP_YP] = {cp, row + YW'(1), col};
  assign raddr[TAP_ZO] = {op, row, col};

  for (genvar t = 0; t < TAP_COUNT; t++) begin : g_tap
    if (t < TAP_YM || (t < TAP_ZO && AXIS_COUNT >= 2) || AXIS_COUNT >= 3) begin : g_ram
      sdiff_ram #(
        .WIDTH (RW),
        .DEPTH (2 ** AW)
      ) u_ram (
        .clk   (clk),
        .we    (accept),
        .waddr (waddr),
        .wdata (cur_row),
        .re    (en1),
        .raddr (raddr[t]),
        .rdata (rdata[t])
      );
    end else begin : g_none
      assign rdata[t] = '0;
    end
  end

  // stage 1 holds the current point beside the RAM outputs
  logic [RW-1:0] cur_q;
  sdiff_meta_t   meta1, meta2, meta3, meta4;

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
      v2 <= 1'b0;
      v3 <= 1'b0;
      v4 <= 1'b0;
    end else begin
      if (en1) v1 <= accept && interior;
      if (en2) v2 <= v1;
      if (en3) v3 <= v2;
      if (en4) v4 <= v3;
    end
  end

  always_ff @(posedge clk) begin
    if (en1) begin
      cur_q <= cur_row;
      meta1 <= meta0;
    end
    if (en2) meta2 <= meta1;
    if (en3) meta3 <= meta2;
    if (en4) meta4 <= meta3;
  end

  // field lanes
  logic [VALUE_WIDTH:0] lane_max [FIELD_COUNT];

  for (genvar f = 0; f < FIELD_COUNT; f++) begin : g_lane
    sdiff_lane #(
      .VALUE_WIDTH (VALUE_WIDTH),
      .AXIS_COUNT  (AXIS_COUNT)
    ) u_lane (
      .clk      (clk),
      .en_a     (en2),
      .en_b     (en3),
      .center   (rdata[TAP_C][f*VALUE_WIDTH +: VALUE_WIDTH]),
      .x_minus  (rdata[TAP_XM][f*VALUE_WIDTH +: VALUE_WIDTH]),
      .x_plus   (rdata[TAP_XP][f*VALUE_WIDTH +: VALUE_WIDTH]),
      .y_minus  (rdata[TAP_YM][f*VALUE_WIDTH +: VALUE_WIDTH]),
      .y_plus   (rdata[TAP_YP][f*VALUE_WIDTH +: VALUE_WIDTH]),
      .z_minus  (rdata[TAP_ZO][f*VALUE_WIDTH +: VALUE_WIDTH]),
      .z_plus   (cur_q[f*VALUE_WIDTH +: VALUE_WIDTH]),
      .lane_max (lane_max[f])
    );
  end

  logic [VALUE_WIDTH:0] error_max;

  sdiff_merge #(
    .VALUE_WIDTH (VALUE_WIDTH)
  ) u_merge (
    .clk       (clk),
    .en        (en4),
    .lane_max  (lane_max),
    .error_max (error_max)
  );

  assign errors.valid       = v4;
  assign errors.error_value = error_max;
  assign errors.index_x     = meta4.index_x;
  assign errors.index_y     = meta4.index_y;
  assign errors.index_z     = meta4.index_z;
  assign errors.last_point  = meta4.last_point;
endmodule

`default_nettype wire
